FILE: hw/rtl/sorted_key_table_defines.svh
// Assertion macros used by the table controller RTL.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SKT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted key table check failed");

`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted key table check failed");

`else

`define SKT_ASSERT_IMP(label, clk, rst, ante, cons)

`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

   localparam int KEY_WIDTH         = 64;
   localparam int REQ_PAYLOAD_WIDTH = 32;
   localparam int MAX_PAYLOAD_WIDTH = 64;
   localparam int OP_WIDTH          = 2;
   localparam int STATUS_WIDTH      = 2;
   localparam int POSITION_WIDTH    = 6;
   localparam int COUNT_WIDTH       = 7;
   localparam int CAP_WIDTH         = 7;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 7'd64;

   localparam logic [OP_WIDTH-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_REMOVE = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_CMP   = 6'b000100,
      S_SHIFT = 6'b001000,
      S_WRITE = 6'b010000,
      S_DONE  = 6'b100000
   } skt_state_type;

endpackage

FILE: hw/rtl/skt_req_if.sv
`timescale 1ns / 1ps

interface skt_req_if import skt_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [OP_WIDTH-1:0]          op;
   logic [KEY_WIDTH-1:0]         key;
   logic [REQ_PAYLOAD_WIDTH-1:0] payload;

   modport source (output valid, op, key, payload, input ready);
   modport sink (input valid, op, key, payload, output ready);
endinterface

FILE: hw/rtl/skt_rsp_if.sv
`timescale 1ns / 1ps

interface skt_rsp_if import skt_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [STATUS_WIDTH-1:0]      status;
   logic                         found;
   logic [POSITION_WIDTH-1:0]    position;
   logic [REQ_PAYLOAD_WIDTH-1:0] found_payload;
   logic [COUNT_WIDTH-1:0]       entry_count;

   modport source (output valid, status, found, position, found_payload, entry_count,
                   input ready);
   modport sink (input valid, status, found, position, found_payload, entry_count,
                 output ready);
endinterface

FILE: hw/rtl/sorted_key_table.sv
// Each request is served one at a time; the next request is taken once the response is queued.
// A lookup is a binary search with one memory read and one compare per step.
// Insert and remove shift the entries past the position by one place, then insert writes its entry.
// The entry memory has a single read port and a single write port.
// Synchronous reset empties the table and sets capacity to 64; memory contents are not cleared.
`timescale 1ns / 1ps

module sorted_key_table import skt_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   skt_req_if.sink              req_chan,
   skt_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int MW = KEY_WIDTH + PAYLOAD_WIDTH;

   logic [CAP_WIDTH-1:0] capacity_ff, capacity_in;
   logic                 mem_rd_en;
   logic [IW-1:0]        mem_rd_addr;
   logic [MW-1:0]        mem_rd_data;
   logic                 mem_wr_en;
   logic [IW-1:0]        mem_wr_addr;
   logic [MW-1:0]        mem_wr_data;

   assign capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   skt_ctrl #(
      .DEPTH         (DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   skt_mem #(
      .DEPTH (DEPTH),
      .WIDTH (MW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule

FILE: hw/rtl/skt_mem.sv
`timescale 1ns / 1ps

module skt_mem import skt_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 96,
   localparam int IW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [IW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] entry_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/skt_ctrl.sv
`timescale 1ns / 1ps
`include "sorted_key_table_defines.svh"

module skt_ctrl import skt_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int PAYLOAD_WIDTH = 32,
   localparam int IW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1),
   localparam int MW = KEY_WIDTH + PAYLOAD_WIDTH,
   localparam int CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CAP_WIDTH-1:0] capacity,
   skt_req_if.sink              req_chan,
   skt_rsp_if.source            rsp_chan,
   output logic                 mem_rd_en,
   output logic [IW-1:0]        mem_rd_addr,
   input  logic [MW-1:0]        mem_rd_data,
   output logic                 mem_wr_en,
   output logic [IW-1:0]        mem_wr_addr,
   output logic [MW-1:0]        mem_wr_data
);

   skt_state_type state_ff, state_in;
   logic                     ins_ff, ins_in;
   logic                     rem_ff, rem_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] pl_ff, pl_in;
   logic [CW-1:0]            lo_ff, lo_in;
   logic [CW-1:0]            hi_ff, hi_in;
   logic [IW-1:0]            mid_ff, mid_in;
   logic [IW-1:0]            pos_ff, pos_in;
   logic                     found_ff, found_in;
   logic [PAYLOAD_WIDTH-1:0] fpl_ff, fpl_in;
   logic [STATUS_WIDTH-1:0]  status_ff, status_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [IW-1:0]            rp_ff, rp_in;
   logic [CW-1:0]            left_ff, left_in;
   logic                     pend_ff, pend_in;
   logic [IW-1:0]            wa_ff, wa_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0]      rsp_status_ff, rsp_status_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [POSITION_WIDTH-1:0]    rsp_position_ff, rsp_position_in;
   logic [REQ_PAYLOAD_WIDTH-1:0] rsp_fpl_ff, rsp_fpl_in;
   logic [COUNT_WIDTH-1:0]       rsp_count_ff, rsp_count_in;

   logic [CW-1:0]                span;
   logic [CW-1:0]                mid_sum;
   logic [IW-1:0]                mid_w;
   logic [CW-1:0]                mid_next;
   logic [KEY_WIDTH-1:0]         rd_key;
   logic [PAYLOAD_WIDTH-1:0]     rd_pl;
   logic                         full;
   logic                         req_accept;
   logic                         rsp_free;
   logic [MAX_PAYLOAD_WIDTH-1:0] req_pl_ext;
   logic [MAX_PAYLOAD_WIDTH-1:0] fpl_ext;

   assign span       = hi_ff - lo_ff - CW'(1);
   assign mid_sum    = lo_ff + (span >> 1);
   assign mid_w      = mid_sum[IW-1:0];
   assign mid_next   = CW'(mid_ff) + CW'(1);
   assign rd_key     = mem_rd_data[MW-1 -: KEY_WIDTH];
   assign rd_pl      = mem_rd_data[PAYLOAD_WIDTH-1:0];
   assign full       = (CMPW'(count_ff) >= CMPW'(capacity)) || (count_ff == CW'(DEPTH));
   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_pl_ext = MAX_PAYLOAD_WIDTH'(req_chan.payload);
   assign fpl_ext    = MAX_PAYLOAD_WIDTH'(fpl_ff);

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      ins_in    = ins_ff;
      rem_in    = rem_ff;
      key_in    = key_ff;
      pl_in     = pl_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      fpl_in    = fpl_ff;
      status_in = status_ff;
      count_in  = count_ff;
      rp_in     = rp_ff;
      left_in   = left_ff;
      pend_in   = pend_ff;
      wa_in     = wa_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_fpl_in      = rsp_fpl_ff;
      rsp_count_in    = rsp_count_ff;

      mem_rd_en   = 1'b0;
      mem_rd_addr = rp_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = wa_ff;
      mem_wr_data = mem_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               ins_in    = (req_chan.op == OP_INSERT);
               rem_in    = (req_chan.op == OP_REMOVE);
               key_in    = req_chan.key;
               pl_in     = req_pl_ext[PAYLOAD_WIDTH-1:0];
               lo_in     = '0;
               hi_in     = count_ff;
               pos_in    = '0;
               found_in  = 1'b0;
               fpl_in    = '0;
               status_in = STATUS_DONE;
               if ((req_chan.op == OP_INSERT) && full) begin
                  status_in = STATUS_FULL;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (lo_ff < hi_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid_w;
               mid_in      = mid_w;
               state_in    = S_CMP;
            end else if (ins_ff) begin
               pos_in   = lo_ff[IW-1:0];
               left_in  = count_ff - lo_ff;
               rp_in    = IW'(count_ff - CW'(1));
               pend_in  = 1'b0;
               state_in = S_SHIFT;
            end else begin
               status_in = STATUS_NOT_FOUND;
               state_in  = S_DONE;
            end
         end
         S_CMP: begin
            state_in = S_READ;
            if (ins_ff) begin
               if (rd_key < key_ff) begin
                  lo_in = mid_next;
               end else begin
                  hi_in = CW'(mid_ff);
               end
            end else if (rd_key == key_ff) begin
               found_in = 1'b1;
               pos_in   = mid_ff;
               fpl_in   = rd_pl;
               if (rem_ff) begin
                  left_in  = count_ff - mid_next;
                  rp_in    = mid_ff + IW'(1);
                  pend_in  = 1'b0;
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end else if (key_ff < rd_key) begin
               hi_in = CW'(mid_ff);
            end else begin
               lo_in = mid_next;
            end
         end
         S_SHIFT: begin
            if (left_ff != '0) begin
               mem_rd_en = 1'b1;
               rp_in     = ins_ff ? (rp_ff - IW'(1)) : (rp_ff + IW'(1));
               wa_in     = ins_ff ? (rp_ff + IW'(1)) : (rp_ff - IW'(1));
               left_in   = left_ff - CW'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if ((left_ff == '0) && !pend_ff) begin
               if (ins_ff) begin
                  state_in = S_WRITE;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end
            end
         end
         S_WRITE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_ff;
            mem_wr_data = {key_ff, pl_ff};
            count_in    = count_ff + CW'(1);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_found_in    = found_ff;
               rsp_position_in = POSITION_WIDTH'(pos_ff);
               rsp_fpl_in      = fpl_ext[REQ_PAYLOAD_WIDTH-1:0];
               rsp_count_in    = COUNT_WIDTH'(count_ff);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_ff          <= ins_in;
      rem_ff          <= rem_in;
      key_ff          <= key_in;
      pl_ff           <= pl_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      pos_ff          <= pos_in;
      found_ff        <= found_in;
      fpl_ff          <= fpl_in;
      status_ff       <= status_in;
      rp_ff           <= rp_in;
      left_ff         <= left_in;
      wa_ff           <= wa_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_fpl_ff      <= rsp_fpl_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.found         = rsp_found_ff;
   assign rsp_chan.position      = rsp_position_ff;
   assign rsp_chan.found_payload = rsp_fpl_ff;
   assign rsp_chan.entry_count   = rsp_count_ff;

   `SKT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `SKT_ASSERT_IMP(a_write_phase, clock, reset, mem_wr_en,
                   (state_ff == S_SHIFT) || (state_ff == S_WRITE))
   `SKT_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != S_IDLE)
   `SKT_ASSERT_IMP(a_search_window, clock, reset,
                   (state_ff == S_READ) || (state_ff == S_CMP), lo_ff <= hi_ff)
   `SKT_ASSERT_IMP(a_count_only_when_busy, clock, reset,
                   (state_ff == S_IDLE) || (state_ff == S_READ) || (state_ff == S_CMP),
                   count_in == count_ff)

endmodule

FILE: verif/sorted_key_table_tb.sv
`timescale 1ns / 1ps

module sorted_key_table_tb;
   import skt_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int PHASES = 13;
   localparam int PHASE_ITEMS = 150;
   localparam int POOL_SIZE = 24;
   localparam logic [OP_WIDTH-1:0] OP_SPARE = 2'd3;

   class table_scoreboard;
      logic [KEY_WIDTH-1:0] key_copy[TABLE_DEPTH];
      logic [REQ_PAYLOAD_WIDTH-1:0] payload_copy[TABLE_DEPTH];
      int unsigned fill;
      logic [CAP_WIDTH-1:0] capacity;
      int unsigned errors;
      logic [STATUS_WIDTH-1:0] want_status[$];
      logic want_found[$];
      logic [POSITION_WIDTH-1:0] want_position[$];
      logic [REQ_PAYLOAD_WIDTH-1:0] want_payload[$];
      logic [COUNT_WIDTH-1:0] want_count[$];

      function new();
         fill = 0;
         capacity = CAP_RESET;
         errors = 0;
      endfunction

      function void set_capacity(logic [CAP_WIDTH-1:0] value);
         capacity = value;
      endfunction

      function bit idle();
         return want_status.size() == 0;
      endfunction

      // Binary search over the filled part; the first hit on a duplicate key wins.
      function bit find_key(logic [KEY_WIDTH-1:0] key, output int unsigned at);
         int unsigned lo, hi, mid;
         lo = 0;
         hi = fill;
         at = 0;
         while (lo < hi) begin
            mid = lo + (hi - lo - 1) / 2;
            if (key_copy[mid] == key) begin
               at = mid;
               return 1'b1;
            end
            if (key < key_copy[mid]) hi = mid;
            else lo = mid + 1;
         end
         return 1'b0;
      endfunction

      function void apply_request(logic [OP_WIDTH-1:0] op, logic [KEY_WIDTH-1:0] key,
                                  logic [REQ_PAYLOAD_WIDTH-1:0] payload);
         logic [STATUS_WIDTH-1:0] status;
         logic hit;
         logic [POSITION_WIDTH-1:0] position;
         logic [REQ_PAYLOAD_WIDTH-1:0] hit_payload;
         int unsigned limit, at, i;
         status = STATUS_DONE;
         hit = 1'b0;
         position = '0;
         hit_payload = '0;
         limit = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
         if (op == OP_INSERT) begin
            if (fill >= limit) begin
               status = STATUS_FULL;
            end else begin
               at = 0;
               while (at < fill && key_copy[at] < key) at++;
               for (i = fill; i > at; i--) begin
                  key_copy[i] = key_copy[i - 1];
                  payload_copy[i] = payload_copy[i - 1];
               end
               key_copy[at] = key;
               payload_copy[at] = payload;
               fill++;
               position = at[POSITION_WIDTH-1:0];
            end
         end else if (find_key(key, at)) begin
            hit = 1'b1;
            position = at[POSITION_WIDTH-1:0];
            hit_payload = payload_copy[at];
            if (op == OP_REMOVE) begin
               for (i = at; i + 1 < fill; i++) begin
                  key_copy[i] = key_copy[i + 1];
                  payload_copy[i] = payload_copy[i + 1];
               end
               fill--;
            end
         end else begin
            status = STATUS_NOT_FOUND;
         end
         want_status.push_back(status);
         want_found.push_back(hit);
         want_position.push_back(position);
         want_payload.push_back(hit_payload);
         want_count.push_back(fill[COUNT_WIDTH-1:0]);
      endfunction

      function void check_reply(logic [STATUS_WIDTH-1:0] status, logic found,
                                logic [POSITION_WIDTH-1:0] position,
                                logic [REQ_PAYLOAD_WIDTH-1:0] found_payload,
                                logic [COUNT_WIDTH-1:0] entry_count);
         logic [STATUS_WIDTH-1:0] e_status;
         logic e_found;
         logic [POSITION_WIDTH-1:0] e_position;
         logic [REQ_PAYLOAD_WIDTH-1:0] e_payload;
         logic [COUNT_WIDTH-1:0] e_count;
         if (want_status.size() == 0) begin
            $error("Response arrived with no request outstanding.");
            errors++;
            return;
         end
         e_status = want_status.pop_front();
         e_found = want_found.pop_front();
         e_position = want_position.pop_front();
         e_payload = want_payload.pop_front();
         e_count = want_count.pop_front();
         if (status !== e_status) begin
            $error("status: expected %0d, actual %0d", e_status, status);
            errors++;
         end
         if (found !== e_found) begin
            $error("found: expected %0d, actual %0d", e_found, found);
            errors++;
         end
         if (position !== e_position) begin
            $error("position: expected %0d, actual %0d", e_position, position);
            errors++;
         end
         if (found_payload !== e_payload) begin
            $error("found_payload: expected %h, actual %h", e_payload, found_payload);
            errors++;
         end
         if (entry_count !== e_count) begin
            $error("entry_count: expected %0d, actual %0d", e_count, entry_count);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CAP_WIDTH-1:0] csr_wr_data;
   skt_req_if req_bus();
   skt_rsp_if rsp_bus();

   table_scoreboard table_model;
   bit steady;
   int unsigned stall_left;
   int unsigned cycle_count;
   logic [KEY_WIDTH-1:0] key_pool[POOL_SIZE];

   sorted_key_table #(
      .DEPTH(TABLE_DEPTH),
      .PAYLOAD_WIDTH(REQ_PAYLOAD_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sorted_key_table] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         table_model.check_reply(rsp_bus.status, rsp_bus.found, rsp_bus.position,
                                 rsp_bus.found_payload, rsp_bus.entry_count);
      end
      if (steady) begin
         rsp_bus.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < 20) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(2, 0);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic drain_table();
      req_bus.valid <= 1'b0;
      while (!table_model.idle()) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic rest_sender();
      int unsigned pick, gap;
      if (steady) return;
      pick = $urandom_range(99);
      if (pick < 2) begin
         drain_table();
      end else begin
         if (pick < 60) gap = 0;
         else if (pick < 90) gap = $urandom_range(3, 1);
         else gap = $urandom_range(30, 5);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic issue(input logic [OP_WIDTH-1:0] op, input logic [KEY_WIDTH-1:0] key,
                        input logic [REQ_PAYLOAD_WIDTH-1:0] payload);
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.key <= key;
      req_bus.payload <= payload;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      table_model.apply_request(op, key, payload);
      rest_sender();
   endtask

   task automatic write_capacity(input logic [CAP_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      table_model.set_capacity(value);
   endtask

   // Neighboring keys are mixed in so that ordering near equal values is exercised.
   function automatic void refill_key_pool();
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         if ($urandom_range(3) == 0) key_pool[i] = key_pool[i - 1] + 64'd1;
         else key_pool[i] = {$urandom, $urandom};
      end
   endfunction

   function automatic logic [KEY_WIDTH-1:0] pick_key();
      if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [REQ_PAYLOAD_WIDTH-1:0] pick_payload();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return $urandom;
   endfunction

   function automatic logic [OP_WIDTH-1:0] pick_op(int unsigned insert_pct);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < insert_pct) return OP_INSERT;
      pick = $urandom_range(99);
      if (pick < 60) return OP_REMOVE;
      if (pick < 95) return OP_LOOKUP;
      return OP_SPARE;
   endfunction

   initial begin
      logic [CAP_WIDTH-1:0] cap_plan[8];
      logic [CAP_WIDTH-1:0] capacity;
      int unsigned insert_pct;
      cap_plan = '{7'd0, 7'd1, 7'd127, 7'd5, 7'd64, 7'd63, 7'd2, 7'd65};
      table_model = new();
      steady = 1'b0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_LOOKUP;
      req_bus.key <= '0;
      req_bus.payload <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(OP_LOOKUP, 64'd0, 32'd0);
      issue(OP_REMOVE, '1, '1);
      issue(OP_INSERT, 64'd0, 32'd0);
      issue(OP_INSERT, '1, '1);
      issue(OP_INSERT, 64'h8000_0000_0000_0000, 32'h1234_5678);
      issue(OP_INSERT, 64'h8000_0000_0000_0000, 32'ha5a5_a5a5);
      issue(OP_INSERT, 64'h4142_4344_4546_4748, 32'd1);
      issue(OP_LOOKUP, 64'd0, 32'd0);
      issue(OP_LOOKUP, '1, 32'd0);
      issue(OP_LOOKUP, 64'h8000_0000_0000_0000, 32'd0);
      issue(OP_SPARE, 64'h4142_4344_4546_4748, 32'hffff_0000);
      issue(OP_LOOKUP, 64'd1, 32'd0);
      issue(OP_REMOVE, 64'h7fff_ffff_ffff_ffff, 32'd0);
      issue(OP_REMOVE, 64'h8000_0000_0000_0000, 32'd0);
      issue(OP_REMOVE, 64'd0, 32'd0);
      issue(OP_LOOKUP, '1, 32'd0);
      issue(OP_INSERT, 64'd1, 32'h5555_5555);
      issue(OP_REMOVE, '1, 32'd0);
      issue(OP_LOOKUP, 64'h8000_0000_0000_0000, 32'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_table();
         capacity = (phase < 8) ? cap_plan[phase] : CAP_WIDTH'($urandom_range(127, 0));
         write_capacity(capacity);
         insert_pct = (phase % 2 == 0) ? 65 : 30;
         refill_key_pool();
         steady <= (phase % 4 == 1);
         repeat (PHASE_ITEMS) issue(pick_op(insert_pct), pick_key(), pick_payload());
      end

      drain_table();
      repeat (200) @(posedge clock);
      if (table_model.errors == 0 && table_model.idle()) begin
         $display("[sorted_key_table] OK");
      end else begin
         $display("[sorted_key_table] ERROR");
      end
      $finish;
   end

endmodule
